// File: rtl/core/assert_macros.svh
// assertion macros used by the checker file psau_checker.sv
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

`endif

// File: rtl/core/psau_pkg.sv
// types, codes and widths of the scroll address unit
// no dependencies; used by every other file of the block but assert_macros.svh
package psau_pkg;

   localparam int ADDR_W   = 15;
   localparam int OP_W     = 3;
   localparam int IDX_W    = 3;
   localparam int DATA_W   = 8;
   localparam int FINE_X_W = 3;
   localparam int COARSE_W = 5;

   // op codes
   localparam logic [OP_W-1:0] OP_REG_WRITE  = 3'd0;
   localparam logic [OP_W-1:0] OP_REG_READ   = 3'd1;
   localparam logic [OP_W-1:0] OP_COARSE_X   = 3'd2;
   localparam logic [OP_W-1:0] OP_Y_INC      = 3'd3;
   localparam logic [OP_W-1:0] OP_COPY_HORIZ = 3'd4;
   localparam logic [OP_W-1:0] OP_COPY_VERT  = 3'd5;

   // cpu register numbers
   localparam logic [IDX_W-1:0] REG_CTRL   = 3'd0;
   localparam logic [IDX_W-1:0] REG_STATUS = 3'd2;
   localparam logic [IDX_W-1:0] REG_SCROLL = 3'd5;
   localparam logic [IDX_W-1:0] REG_ADDR   = 3'd6;
   localparam logic [IDX_W-1:0] REG_DATA   = 3'd7;

   localparam logic [ADDR_W-1:0]   STEP_ROW     = 15'd32;
   localparam logic [ADDR_W-1:0]   STEP_ONE     = 15'd1;
   localparam logic [COARSE_W-1:0] COARSE_LAST  = 5'd31;
   localparam logic [COARSE_W-1:0] ROW_LAST     = 5'd29;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [IDX_W-1:0]  reg_index;
      logic [DATA_W-1:0] write_data;
   } item_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   cur_v;
      logic [ADDR_W-1:0]   tmp_t;
      logic [FINE_X_W-1:0] fine_x;
      logic                toggle;
      logic                inc_by_32;
   } state_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   current_addr;
      logic [ADDR_W-1:0]   temp_addr;
      logic [FINE_X_W-1:0] fine_x;
      logic                toggle;
      logic                access_valid;
      logic [ADDR_W-1:0]   access_addr;
   } result_type;

endpackage

// File: rtl/core/psau_req_if.sv
// input channel of the scroll address unit: valid/ready plus one item
// depends on psau_pkg
interface psau_req_if;
   logic                        valid;
   logic                        ready;
   logic [psau_pkg::OP_W-1:0]   op;
   logic [psau_pkg::IDX_W-1:0]  reg_index;
   logic [psau_pkg::DATA_W-1:0] write_data;

   modport source (output valid, output op, output reg_index, output write_data,
                   input ready);
   modport sink   (input valid, input op, input reg_index, input write_data,
                   output ready);
endinterface

// File: rtl/core/psau_rsp_if.sv
// result channel of the scroll address unit: valid/ready plus one item
// depends on psau_pkg
interface psau_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [psau_pkg::ADDR_W-1:0]   current_addr;
   logic [psau_pkg::ADDR_W-1:0]   temp_addr;
   logic [psau_pkg::FINE_X_W-1:0] fine_x;
   logic                          toggle;
   logic                          access_valid;
   logic [psau_pkg::ADDR_W-1:0]   access_addr;

   modport source (output valid, output current_addr, output temp_addr, output fine_x,
                   output toggle, output access_valid, output access_addr,
                   input ready);
   modport sink   (input valid, input current_addr, input temp_addr, input fine_x,
                   input toggle, input access_valid, input access_addr,
                   output ready);
endinterface

// File: rtl/core/psau_input_reg.sv
// input register of the scroll address unit
// depends on psau_pkg and psau_req_if
module psau_input_reg (
   input  logic               clock,
   input  logic               reset,
   psau_req_if.sink           req_ch,
   input  logic               advance,
   output logic               item_valid,
   output psau_pkg::item_type item
);

   logic               item_valid_ff;
   logic               item_valid_in;
   psau_pkg::item_type item_ff;
   logic               take;

   assign req_ch.ready = !item_valid_ff || advance;
   assign take         = req_ch.valid && req_ch.ready;

   always_comb begin
      item_valid_in = item_valid_ff;
      if (take) begin
         item_valid_in = 1'b1;
      end else if (advance) begin
         item_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
      if (take) begin
         item_ff.op         <= req_ch.op;
         item_ff.reg_index  <= req_ch.reg_index;
         item_ff.write_data <= req_ch.write_data;
      end
   end

   assign item_valid = item_valid_ff;
   assign item       = item_ff;

endmodule

// File: rtl/core/psau_step.sv
// next-state and result logic for one item of the scroll address unit
// depends on psau_pkg
module psau_step (
   input  psau_pkg::state_type  state,
   input  psau_pkg::item_type   item,
   output psau_pkg::state_type  next_state,
   output psau_pkg::result_type result
);

   logic [psau_pkg::ADDR_W-1:0]   v;
   logic [psau_pkg::ADDR_W-1:0]   t;
   logic [psau_pkg::DATA_W-1:0]   d;
   logic [psau_pkg::ADDR_W-1:0]   cx_v;
   logic [psau_pkg::ADDR_W-1:0]   y_v;
   logic [psau_pkg::ADDR_W-1:0]   port_v;
   logic [psau_pkg::ADDR_W-1:0]   addr_lo_t;
   logic [psau_pkg::COARSE_W-1:0] cy;
   logic [psau_pkg::COARSE_W-1:0] cy_next;
   logic                          row_wrap;

   assign v = state.cur_v;
   assign t = state.tmp_t;
   assign d = item.write_data;

   // coarse x wraps into the neighboring horizontal nametable
   assign cx_v = (v[4:0] == psau_pkg::COARSE_LAST) ?
                 {v[14:11], ~v[10], v[9:5], 5'd0} : v + psau_pkg::STEP_ONE;

   // fine y overflows into coarse y; row 29 also flips the vertical nametable
   assign cy       = v[9:5];
   assign row_wrap = (cy == psau_pkg::ROW_LAST);
   assign cy_next  = (row_wrap || cy == psau_pkg::COARSE_LAST) ? 5'd0 : cy + 5'd1;
   assign y_v      = (&v[14:12]) ? {3'd0, v[11] ^ row_wrap, v[10], cy_next, v[4:0]}
                                 : {v[14:12] + 3'd1, v[11:0]};

   assign port_v    = v + (state.inc_by_32 ? psau_pkg::STEP_ROW : psau_pkg::STEP_ONE);
   assign addr_lo_t = {t[14:8], d};

   always_comb begin
      next_state          = state;
      result.access_valid = 1'b0;
      result.access_addr  = '0;
      case (item.op)
         psau_pkg::OP_REG_WRITE, psau_pkg::OP_REG_READ: begin
            if (item.reg_index == psau_pkg::REG_DATA) begin
               result.access_valid = 1'b1;
               result.access_addr  = v;
               next_state.cur_v    = port_v;
            end else if (item.op == psau_pkg::OP_REG_WRITE) begin
               case (item.reg_index)
                  psau_pkg::REG_CTRL: begin
                     next_state.inc_by_32    = d[2];
                     next_state.tmp_t[11:10] = d[1:0];
                  end
                  psau_pkg::REG_SCROLL: begin
                     if (!state.toggle) begin
                        next_state.tmp_t[4:0] = d[7:3];
                        next_state.fine_x     = d[2:0];
                     end else begin
                        next_state.tmp_t[14:12] = d[2:0];
                        next_state.tmp_t[9:5]   = d[7:3];
                     end
                     next_state.toggle = ~state.toggle;
                  end
                  psau_pkg::REG_ADDR: begin
                     if (!state.toggle) begin
                        next_state.tmp_t[14:8] = {1'b0, d[5:0]};
                     end else begin
                        next_state.tmp_t = addr_lo_t;
                        next_state.cur_v = addr_lo_t;
                     end
                     next_state.toggle = ~state.toggle;
                  end
                  default: begin
                  end
               endcase
            end else if (item.reg_index == psau_pkg::REG_STATUS) begin
               next_state.toggle = 1'b0;
            end
         end
         psau_pkg::OP_COARSE_X: begin
            next_state.cur_v = cx_v;
         end
         psau_pkg::OP_Y_INC: begin
            next_state.cur_v = y_v;
         end
         psau_pkg::OP_COPY_HORIZ: begin
            next_state.cur_v[10]  = t[10];
            next_state.cur_v[4:0] = t[4:0];
         end
         psau_pkg::OP_COPY_VERT: begin
            next_state.cur_v[14:11] = t[14:11];
            next_state.cur_v[9:5]   = t[9:5];
         end
         default: begin
         end
      endcase
      result.current_addr = next_state.cur_v;
      result.temp_addr    = next_state.tmp_t;
      result.fine_x       = next_state.fine_x;
      result.toggle       = next_state.toggle;
   end

endmodule

// File: rtl/core/ppu_scroll_address_unit.sv
// Scroll and VRAM address unit: keeps the current address v, the temporary
// address t, fine X, the write toggle and the increment mode, and applies one
// CPU register access or render event per item. It takes one item per clock
// cycle while rsp drains its results; each result is offered on rsp from the
// result register (the input register takes the item at the accepting edge,
// the result register takes its result when the item advances). The rate is
// set by the update of the address state, which every item reads and writes.
// A waiting result holds the input register, which holds req.
// Depends on psau_pkg, psau_req_if, psau_rsp_if, psau_input_reg, psau_step.
module ppu_scroll_address_unit (
   input  logic      clock,
   input  logic      reset,
   psau_req_if.sink  req_ch,
   psau_rsp_if.source rsp_ch
);

   logic                 item_valid;
   psau_pkg::item_type   item;
   logic                 advance;
   psau_pkg::state_type  state_ff;
   psau_pkg::state_type  state_in;
   psau_pkg::result_type result;
   psau_pkg::result_type result_ff;
   logic                 out_valid_ff;
   logic                 out_valid_in;

   psau_input_reg u_input_reg (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   psau_step u_step (
      .state      (state_ff),
      .item       (item),
      .next_state (state_in),
      .result     (result)
   );

   // an item moves on when the result register is empty or being drained
   assign advance = item_valid && (!out_valid_ff || rsp_ch.ready);

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
      if (advance) begin
         result_ff <= result;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.current_addr = result_ff.current_addr;
   assign rsp_ch.temp_addr    = result_ff.temp_addr;
   assign rsp_ch.fine_x       = result_ff.fine_x;
   assign rsp_ch.toggle       = result_ff.toggle;
   assign rsp_ch.access_valid = result_ff.access_valid;
   assign rsp_ch.access_addr  = result_ff.access_addr;

endmodule

// File: rtl/core/psau_checker.sv
// port-level checks of the scroll address unit, bound to the top level
// depends on psau_pkg and assert_macros.svh
`include "assert_macros.svh"

module psau_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [psau_pkg::ADDR_W-1:0]   current_addr,
   input logic [psau_pkg::ADDR_W-1:0]   temp_addr,
   input logic [psau_pkg::FINE_X_W-1:0] fine_x,
   input logic                          toggle,
   input logic                          access_valid,
   input logic [psau_pkg::ADDR_W-1:0]   access_addr
);

   // results hold while stalled
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable({current_addr, temp_addr, fine_x, toggle, access_valid, access_addr}))

   // no data port access reports a zero address
   `ASSERT_SAME(a_no_access_addr, clock, reset, rsp_valid && !access_valid, access_addr == '0)

   // with the result register empty nothing can hold the input back
   `ASSERT_SAME(a_ready_when_empty, clock, reset, !rsp_valid, req_ready)

endmodule

bind ppu_scroll_address_unit psau_checker u_psau_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .current_addr (rsp_ch.current_addr),
   .temp_addr    (rsp_ch.temp_addr),
   .fine_x       (rsp_ch.fine_x),
   .toggle       (rsp_ch.toggle),
   .access_valid (rsp_ch.access_valid),
   .access_addr  (rsp_ch.access_addr)
);

// File: tb/tb_ppu_scroll_address_unit.sv
// self-checking testbench of the scroll and vram address unit
// depends on psau_pkg, psau_req_if, psau_rsp_if and ppu_scroll_address_unit
// directed and random register accesses and render events, checked against an inline predictor
module tb_ppu_scroll_address_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import psau_pkg::*;

   // register numbers and op codes the unit ignores
   localparam logic [IDX_W-1:0] REG_MASK     = 3'd1;
   localparam logic [IDX_W-1:0] REG_OAM_ADDR = 3'd3;
   localparam logic [IDX_W-1:0] REG_OAM_DATA = 3'd4;
   localparam logic [OP_W-1:0]  OP_SPARE_6   = 3'd6;
   localparam logic [OP_W-1:0]  OP_SPARE_7   = 3'd7;

   localparam int RANDOM_ITEMS = 650;
   localparam int TAIL_CYCLES  = 50;

   logic clock;
   logic reset;

   psau_req_if req_ch ();
   psau_rsp_if rsp_ch ();

   ppu_scroll_address_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // predicted address state
   logic [ADDR_W-1:0]   v_addr;
   logic [ADDR_W-1:0]   t_addr;
   logic [FINE_X_W-1:0] fine_scroll;
   logic                latch_toggle;
   logic                row_step;

   item_type   pending_items[$];
   result_type expected_results[$];
   int         error_count;
   int         effective_count;

   int send_gap;
   int recv_stall;
   bit send_burst;
   bit recv_burst;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // mostly short gaps, a few long ones, and stretches with none
   function automatic int draw_gap(inout bit burst);
      int r;
      if ($urandom_range(0, 63) == 0) begin
         burst = !burst;
      end
      r = $urandom_range(0, 99);
      if (burst || r < 60) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(4, 30);
   endfunction

   function automatic logic [OP_W-1:0] rand_op();
      return OP_W'($urandom_range(0, 7));
   endfunction

   function automatic logic [IDX_W-1:0] rand_index();
      return IDX_W'($urandom_range(0, 7));
   endfunction

   function automatic logic [DATA_W-1:0] rand_byte();
      return DATA_W'($urandom_range(0, 255));
   endfunction

   function automatic result_type predict_scroll_step(item_type it);
      result_type          r;
      logic [COARSE_W-1:0] row;
      r = '0;
      case (it.op)
         OP_REG_WRITE, OP_REG_READ: begin
            if (it.reg_index == REG_DATA) begin
               r.access_valid = 1'b1;
               r.access_addr  = v_addr;
               v_addr = v_addr + (row_step ? STEP_ROW : STEP_ONE);
            end else if (it.op == OP_REG_WRITE) begin
               case (it.reg_index)
                  REG_CTRL: begin
                     row_step     = it.write_data[2];
                     t_addr[11:10] = it.write_data[1:0];
                  end
                  REG_SCROLL: begin
                     if (!latch_toggle) begin
                        t_addr[4:0] = it.write_data[7:3];
                        fine_scroll = it.write_data[2:0];
                     end else begin
                        t_addr[14:12] = it.write_data[2:0];
                        t_addr[9:5]   = it.write_data[7:3];
                     end
                     latch_toggle = !latch_toggle;
                  end
                  REG_ADDR: begin
                     if (!latch_toggle) begin
                        t_addr[13:8] = it.write_data[5:0];
                        t_addr[14]   = 1'b0;
                     end else begin
                        t_addr[7:0] = it.write_data;
                        v_addr      = t_addr;
                     end
                     latch_toggle = !latch_toggle;
                  end
                  default: ;
               endcase
            end else if (it.reg_index == REG_STATUS) begin
               latch_toggle = 1'b0;
            end
         end
         OP_COARSE_X: begin
            if (v_addr[4:0] == COARSE_LAST) begin
               v_addr[4:0] = '0;
               v_addr[10]  = !v_addr[10];
            end else begin
               v_addr[4:0] = v_addr[4:0] + 1'b1;
            end
         end
         OP_Y_INC: begin
            if (v_addr[14:12] != '1) begin
               v_addr[14:12] = v_addr[14:12] + 1'b1;
            end else begin
               v_addr[14:12] = '0;
               row = v_addr[9:5];
               if (row == ROW_LAST) begin
                  row = '0;
                  v_addr[11] = !v_addr[11];
               end else if (row == COARSE_LAST) begin
                  row = '0;
               end else begin
                  row = row + 1'b1;
               end
               v_addr[9:5] = row;
            end
         end
         OP_COPY_HORIZ: begin
            v_addr[4:0] = t_addr[4:0];
            v_addr[10]  = t_addr[10];
         end
         OP_COPY_VERT: begin
            v_addr[9:5]   = t_addr[9:5];
            v_addr[11]    = t_addr[11];
            v_addr[14:12] = t_addr[14:12];
         end
         default: ;
      endcase
      r.current_addr = v_addr;
      r.temp_addr    = t_addr;
      r.fine_x       = fine_scroll;
      r.toggle       = latch_toggle;
      return r;
   endfunction

   task automatic push_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                            input logic [DATA_W-1:0] data);
      item_type it;
      bit       ignored;
      it.op         = op;
      it.reg_index  = idx;
      it.write_data = data;
      pending_items.push_back(it);
      ignored = (op > OP_COPY_VERT) ||
                (op == OP_REG_WRITE && !(idx inside {REG_CTRL, REG_SCROLL, REG_ADDR,
                                                     REG_DATA})) ||
                (op == OP_REG_READ && !(idx inside {REG_STATUS, REG_DATA}));
      if (!ignored) begin
         effective_count++;
      end
   endtask

   task automatic wait_all_results();
      @(negedge clock);
      while (pending_items.size() != 0 || req_ch.valid || expected_results.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic add_random_sequence();
      int n;
      n = $urandom_range(0, 9);
      case (n)
         0: begin
            if ($urandom_range(0, 1)) begin
               push_item(OP_REG_READ, REG_STATUS, rand_byte());
            end
            push_item(OP_REG_WRITE, REG_SCROLL, rand_byte());
            push_item(OP_REG_WRITE, REG_SCROLL, rand_byte());
         end
         1: begin
            push_item(OP_REG_READ, REG_STATUS, rand_byte());
            push_item(OP_REG_WRITE, REG_ADDR, rand_byte());
            push_item(OP_REG_WRITE, REG_ADDR, rand_byte());
            repeat ($urandom_range(1, 6)) begin
               push_item($urandom_range(0, 1) ? OP_REG_WRITE : OP_REG_READ, REG_DATA,
                         rand_byte());
            end
         end
         2: push_item(OP_REG_WRITE, REG_CTRL, rand_byte());
         3, 4: begin
            // one scanline worth of fetch events
            repeat ($urandom_range(1, 8)) begin
               push_item(OP_COARSE_X, rand_index(), rand_byte());
            end
            push_item(OP_Y_INC, rand_index(), rand_byte());
            push_item(OP_COPY_HORIZ, rand_index(), rand_byte());
            if ($urandom_range(0, 3) == 0) begin
               push_item(OP_COPY_VERT, rand_index(), rand_byte());
            end
         end
         5: begin
            repeat ($urandom_range(1, 8)) begin
               push_item($urandom_range(0, 1) ? OP_REG_WRITE : OP_REG_READ, REG_DATA,
                         rand_byte());
            end
         end
         6: begin
            repeat ($urandom_range(1, 10)) begin
               push_item(OP_Y_INC, rand_index(), rand_byte());
            end
         end
         7: begin
            // half of a two-write pair
            push_item(OP_REG_WRITE, $urandom_range(0, 1) ? REG_SCROLL : REG_ADDR,
                      rand_byte());
         end
         default: begin
            repeat ($urandom_range(1, 3)) begin
               push_item(rand_op(), rand_index(), rand_byte());
            end
         end
      endcase
   endtask

   // sender: a new item is offered only once the previous one is taken, after a random gap
   always @(posedge clock) begin
      item_type it;
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            it.op         = req_ch.op;
            it.reg_index  = req_ch.reg_index;
            it.write_data = req_ch.write_data;
            expected_results.push_back(predict_scroll_step(it));
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_ch.valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
               it = pending_items.pop_front();
               req_ch.op         <= it.op;
               req_ch.reg_index  <= it.reg_index;
               req_ch.write_data <= it.write_data;
               req_ch.valid      <= 1'b1;
               send_gap = draw_gap(send_burst);
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         recv_stall = 0;
      end else if (recv_stall > 0) begin
         recv_stall--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
         recv_stall = draw_gap(recv_burst);
      end
   end

   task automatic check_field(input string name, input logic [ADDR_W-1:0] want,
                              input logic [ADDR_W-1:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_results.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result, expected none, got current_addr %0h",
                     $time, rsp_ch.current_addr);
         end else begin
            want = expected_results.pop_front();
            check_field("current_addr", want.current_addr, rsp_ch.current_addr);
            check_field("temp_addr", want.temp_addr, rsp_ch.temp_addr);
            check_field("fine_x", ADDR_W'(want.fine_x), ADDR_W'(rsp_ch.fine_x));
            check_field("toggle", ADDR_W'(want.toggle), ADDR_W'(rsp_ch.toggle));
            check_field("access_valid", ADDR_W'(want.access_valid),
                        ADDR_W'(rsp_ch.access_valid));
            check_field("access_addr", want.access_addr, rsp_ch.access_addr);
         end
      end
   end

   initial begin
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.op         = OP_REG_WRITE;
      req_ch.reg_index  = REG_CTRL;
      req_ch.write_data = '0;
      rsp_ch.ready      = 1'b0;
      v_addr            = '0;
      t_addr            = '0;
      fine_scroll       = '0;
      latch_toggle      = 1'b0;
      row_step          = 1'b0;
      error_count       = 0;
      effective_count   = 0;
      send_burst        = 1'b0;
      recv_burst        = 1'b0;

      // t and v to all ones, then a data access that wraps past the top
      push_item(OP_REG_READ, REG_STATUS, 8'h00);
      push_item(OP_REG_WRITE, REG_CTRL, 8'hFF);
      push_item(OP_REG_WRITE, REG_SCROLL, 8'hFF);
      push_item(OP_REG_WRITE, REG_SCROLL, 8'hFF);
      push_item(OP_COPY_HORIZ, REG_CTRL, 8'h00);
      push_item(OP_COPY_VERT, REG_CTRL, 8'h00);
      push_item(OP_REG_READ, REG_DATA, 8'h00);
      push_item(OP_Y_INC, REG_CTRL, 8'h00);
      // coarse x wraps and flips the horizontal nametable
      push_item(OP_COARSE_X, REG_CTRL, 8'h00);
      push_item(OP_COPY_VERT, REG_CTRL, 8'h00);
      // fine y 7 at row 31 wraps without a nametable flip
      push_item(OP_Y_INC, REG_CTRL, 8'h00);
      push_item(OP_REG_WRITE, REG_SCROLL, 8'h00);
      push_item(OP_REG_READ, REG_STATUS, 8'hFF);
      push_item(OP_REG_WRITE, REG_SCROLL, 8'h00);
      // row 29 with fine y 7 flips the vertical nametable
      push_item(OP_REG_WRITE, REG_SCROLL, 8'hEF);
      push_item(OP_COPY_VERT, REG_CTRL, 8'h00);
      push_item(OP_Y_INC, REG_CTRL, 8'h00);
      push_item(OP_REG_WRITE, REG_CTRL, 8'h00);
      push_item(OP_REG_WRITE, REG_ADDR, 8'hFF);
      push_item(OP_REG_WRITE, REG_ADDR, 8'hFF);
      push_item(OP_REG_WRITE, REG_DATA, 8'h55);
      push_item(OP_REG_WRITE, REG_MASK, 8'hFF);
      push_item(OP_REG_WRITE, REG_OAM_ADDR, 8'hFF);
      push_item(OP_REG_READ, REG_OAM_DATA, 8'hFF);
      push_item(OP_REG_READ, REG_SCROLL, 8'hFF);
      push_item(OP_SPARE_6, REG_DATA, 8'hFF);
      push_item(OP_SPARE_7, REG_DATA, 8'hFF);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      wait_all_results();
      effective_count = 0;
      while (effective_count < RANDOM_ITEMS / 2) begin
         add_random_sequence();
      end
      // let the unit drain completely before the second half
      wait_all_results();
      while (effective_count < RANDOM_ITEMS) begin
         add_random_sequence();
      end
      wait_all_results();
      repeat (TAIL_CYCLES) @(negedge clock);

      if (error_count == 0) begin
         $display("ppu_scroll_address_unit verification clean");
      end else begin
         $display("ppu_scroll_address_unit verification failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("ppu_scroll_address_unit verification failed");
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/psau_pkg.sv
rtl/core/psau_req_if.sv
rtl/core/psau_rsp_if.sv
rtl/core/psau_input_reg.sv
rtl/core/psau_step.sv
rtl/core/ppu_scroll_address_unit.sv
rtl/core/psau_checker.sv
tb/tb_ppu_scroll_address_unit.sv
